>>> rtl/cau_pkg.sv
// shared types and constants for the complex arithmetic unit
package cau_pkg;

    // default word and fraction widths
    localparam int CAU_WORD_BITS = 32;
    localparam int CAU_FRAC_BITS = 16;

    // operation codes
    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } cau_action_t;

    // per-item control that travels down the pipeline
    typedef struct packed {
        logic valid;
        logic is_div;
        logic dz;
        logic eq;
        logic ovf;
        logic neg_re;
        logic neg_im;
        logic big_re;
        logic big_im;
    } cau_ctl_t;

endpackage

>>> rtl/cau_front.sv
// front stages: operand capture, products, sums, truncation, saturation, divider setup
module cau_front #(
    parameter int WORD_BITS = cau_pkg::CAU_WORD_BITS,
    parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [1:0]                          action,
    input  logic signed [WORD_BITS-1:0]         a_re,
    input  logic signed [WORD_BITS-1:0]         a_im,
    input  logic signed [WORD_BITS-1:0]         b_re,
    input  logic signed [WORD_BITS-1:0]         b_im,
    output cau_pkg::cau_ctl_t                   ctl_out,
    output logic [2*WORD_BITS-1:0]              den_out,
    output logic [2*WORD_BITS+FRAC_BITS-1:0]    rem_re_out,
    output logic [2*WORD_BITS+FRAC_BITS-1:0]    rem_im_out,
    output logic [WORD_BITS-1:0]                res_re_out,
    output logic [WORD_BITS-1:0]                res_im_out
);
    import cau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W + 1;
    localparam int DW = 2 * W;
    localparam int NW = 2 * W + F;
    localparam int CW = 3 * W + F + 1;
    localparam logic signed [PW-1:0] BIAS = PW'((65'd1 << F) - 65'd1);
    localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};

    // stage 1: operand capture
    logic                v1_reg;
    logic [1:0]          act1_reg;
    logic signed [W-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic                eq1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        act1_reg <= action;
        ar1_reg  <= a_re;
        ai1_reg  <= a_im;
        br1_reg  <= b_re;
        bi1_reg  <= b_im;
        eq1_reg  <= (a_re == b_re) && (a_im == b_im);
    end

    // stage 2: products and plain sums
    logic                   v2_reg;
    logic [1:0]             act2_reg;
    logic                   eq2_reg, dz2_reg;
    logic signed [DW-1:0]   p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, p_bb_reg, p_cc_reg;
    logic signed [W:0]      sum_re2_reg, sum_im2_reg;
    logic signed [W:0]      sum_re_next, sum_im_next;

    always_comb
    begin
        if (act1_reg == ACT_SUB)
        begin
            sum_re_next = {ar1_reg[W-1], ar1_reg} - {br1_reg[W-1], br1_reg};
            sum_im_next = {ai1_reg[W-1], ai1_reg} - {bi1_reg[W-1], bi1_reg};
        end
        else
        begin
            sum_re_next = {ar1_reg[W-1], ar1_reg} + {br1_reg[W-1], br1_reg};
            sum_im_next = {ai1_reg[W-1], ai1_reg} + {bi1_reg[W-1], bi1_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        act2_reg    <= act1_reg;
        eq2_reg     <= eq1_reg;
        dz2_reg     <= (act1_reg == ACT_DIV) && (br1_reg == '0) && (bi1_reg == '0);
        p_rr_reg    <= ar1_reg * br1_reg;
        p_ii_reg    <= ai1_reg * bi1_reg;
        p_ir_reg    <= ai1_reg * br1_reg;
        p_ri_reg    <= ar1_reg * bi1_reg;
        p_bb_reg    <= br1_reg * br1_reg;
        p_cc_reg    <= bi1_reg * bi1_reg;
        sum_re2_reg <= sum_re_next;
        sum_im2_reg <= sum_im_next;
    end

    // stage 3: combine products per operation, squared divisor magnitude
    logic                   v3_reg;
    logic [1:0]             act3_reg;
    logic                   eq3_reg, dz3_reg;
    logic signed [PW-1:0]   pre3_re_reg, pre3_im_reg;
    logic [DW-1:0]          den3_reg;
    logic signed [PW-1:0]   pre3_re_next, pre3_im_next;

    always_comb
    begin
        unique case (act2_reg)
            ACT_ADD, ACT_SUB:
            begin
                pre3_re_next = {{(PW-W-1){sum_re2_reg[W]}}, sum_re2_reg};
                pre3_im_next = {{(PW-W-1){sum_im2_reg[W]}}, sum_im2_reg};
            end
            ACT_MUL:
            begin
                pre3_re_next = PW'(p_rr_reg) - PW'(p_ii_reg);
                pre3_im_next = PW'(p_ir_reg) + PW'(p_ri_reg);
            end
            ACT_DIV:
            begin
                pre3_re_next = PW'(p_rr_reg) + PW'(p_ii_reg);
                pre3_im_next = PW'(p_ir_reg) - PW'(p_ri_reg);
            end
            default:
            begin
                pre3_re_next = '0;
                pre3_im_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        act3_reg    <= act2_reg;
        eq3_reg     <= eq2_reg;
        dz3_reg     <= dz2_reg;
        pre3_re_reg <= pre3_re_next;
        pre3_im_reg <= pre3_im_next;
        den3_reg    <= $unsigned(p_bb_reg) + $unsigned(p_cc_reg);
    end

    // stage 4: truncate products toward zero, take numerator magnitudes
    logic                   v4_reg;
    logic [1:0]             act4_reg;
    logic                   eq4_reg, dz4_reg, neg4_re_reg, neg4_im_reg;
    logic signed [PW-1:0]   pre4_re_reg, pre4_im_reg;
    logic [DW-1:0]          den4_reg;
    logic signed [PW-1:0]   pre4_re_next, pre4_im_next;
    logic signed [PW-1:0]   biased_re, biased_im;

    always_comb
    begin
        biased_re = pre3_re_reg + (pre3_re_reg[PW-1] ? BIAS : '0);
        biased_im = pre3_im_reg + (pre3_im_reg[PW-1] ? BIAS : '0);
        pre4_re_next = pre3_re_reg;
        pre4_im_next = pre3_im_reg;
        if (act3_reg == ACT_MUL)
        begin
            pre4_re_next = biased_re >>> F;
            pre4_im_next = biased_im >>> F;
        end
        else if (act3_reg == ACT_DIV)
        begin
            if (dz3_reg)
            begin
                // minus one in the fraction format
                pre4_re_next = ~BIAS;
                pre4_im_next = '0;
            end
            else
            begin
                pre4_re_next = pre3_re_reg[PW-1] ? -pre3_re_reg : pre3_re_reg;
                pre4_im_next = pre3_im_reg[PW-1] ? -pre3_im_reg : pre3_im_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        act4_reg    <= act3_reg;
        eq4_reg     <= eq3_reg;
        dz4_reg     <= dz3_reg;
        neg4_re_reg <= pre3_re_reg[PW-1];
        neg4_im_reg <= pre3_im_reg[PW-1];
        pre4_re_reg <= pre4_re_next;
        pre4_im_reg <= pre4_im_next;
        den4_reg    <= den3_reg;
    end

    // stage 5: saturate direct results, scale numerators, quotient range check
    logic          fit_re, fit_im;
    logic [NW-1:0] num_re, num_im;
    logic [CW-1:0] den_top;
    cau_ctl_t      ctl_next;
    cau_ctl_t      ctl_reg;
    logic [DW-1:0] den5_reg;
    logic [NW-1:0] rem_re5_reg, rem_im5_reg;
    logic [W-1:0]  res_re5_reg, res_im5_reg;
    logic [W-1:0]  sat_re, sat_im;

    always_comb
    begin
        fit_re  = (&pre4_re_reg[PW-1:W-1]) || !(|pre4_re_reg[PW-1:W-1]);
        fit_im  = (&pre4_im_reg[PW-1:W-1]) || !(|pre4_im_reg[PW-1:W-1]);
        sat_re  = fit_re ? pre4_re_reg[W-1:0] : (pre4_re_reg[PW-1] ? WORD_MIN : WORD_MAX);
        sat_im  = fit_im ? pre4_im_reg[W-1:0] : (pre4_im_reg[PW-1] ? WORD_MIN : WORD_MAX);
        num_re  = NW'(pre4_re_reg[DW-1:0]) << F;
        num_im  = NW'(pre4_im_reg[DW-1:0]) << F;
        den_top = CW'(den4_reg) << (W + 1);
        ctl_next.valid  = v4_reg;
        ctl_next.is_div = (act4_reg == ACT_DIV) && !dz4_reg;
        ctl_next.dz     = dz4_reg;
        ctl_next.eq     = eq4_reg;
        ctl_next.ovf    = !fit_re || !fit_im;
        ctl_next.neg_re = neg4_re_reg;
        ctl_next.neg_im = neg4_im_reg;
        ctl_next.big_re = CW'(num_re) >= den_top;
        ctl_next.big_im = CW'(num_im) >= den_top;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den5_reg    <= den4_reg;
        rem_re5_reg <= num_re;
        rem_im5_reg <= num_im;
        res_re5_reg <= sat_re;
        res_im5_reg <= sat_im;
    end

    assign ctl_out    = ctl_reg;
    assign den_out    = den5_reg;
    assign rem_re_out = rem_re5_reg;
    assign rem_im_out = rem_im5_reg;
    assign res_re_out = res_re5_reg;
    assign res_im_out = res_im5_reg;

endmodule

>>> rtl/cau_div_stage.sv
// one restoring division stage: decides quotient bit K for both result parts
module cau_div_stage #(
    parameter int WORD_BITS = cau_pkg::CAU_WORD_BITS,
    parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS,
    parameter int K         = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cau_pkg::cau_ctl_t                   ctl_in,
    input  logic [2*WORD_BITS-1:0]              den_in,
    input  logic [2*WORD_BITS+FRAC_BITS-1:0]    rem_re_in,
    input  logic [2*WORD_BITS+FRAC_BITS-1:0]    rem_im_in,
    input  logic [WORD_BITS:0]                  q_re_in,
    input  logic [WORD_BITS:0]                  q_im_in,
    input  logic [WORD_BITS-1:0]                res_re_in,
    input  logic [WORD_BITS-1:0]                res_im_in,
    output cau_pkg::cau_ctl_t                   ctl_out,
    output logic [2*WORD_BITS-1:0]              den_out,
    output logic [2*WORD_BITS+FRAC_BITS-1:0]    rem_re_out,
    output logic [2*WORD_BITS+FRAC_BITS-1:0]    rem_im_out,
    output logic [WORD_BITS:0]                  q_re_out,
    output logic [WORD_BITS:0]                  q_im_out,
    output logic [WORD_BITS-1:0]                res_re_out,
    output logic [WORD_BITS-1:0]                res_im_out
);
    import cau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int NW = 2 * W + FRAC_BITS;
    localparam int CW = 3 * W + FRAC_BITS + 1;

    logic [CW-1:0] trial, ext_re, ext_im;
    logic          ge_re, ge_im;
    logic [NW-1:0] rem_re_next, rem_im_next;
    logic [W:0]    q_re_next, q_im_next;
    cau_ctl_t      ctl_reg;
    logic [2*W-1:0] den_reg;
    logic [NW-1:0] rem_re_reg, rem_im_reg;
    logic [W:0]    q_re_reg, q_im_reg;
    logic [W-1:0]  res_re_reg, res_im_reg;

    // compare against the shifted divisor and subtract when it fits
    always_comb
    begin
        trial       = CW'(den_in) << K;
        ext_re      = CW'(rem_re_in);
        ext_im      = CW'(rem_im_in);
        ge_re       = ext_re >= trial;
        ge_im       = ext_im >= trial;
        rem_re_next = ge_re ? NW'(ext_re - trial) : rem_re_in;
        rem_im_next = ge_im ? NW'(ext_im - trial) : rem_im_in;
        q_re_next   = q_re_in;
        q_im_next   = q_im_in;
        q_re_next[K] = ge_re;
        q_im_next[K] = ge_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg    <= den_in;
        rem_re_reg <= rem_re_next;
        rem_im_reg <= rem_im_next;
        q_re_reg   <= q_re_next;
        q_im_reg   <= q_im_next;
        res_re_reg <= res_re_in;
        res_im_reg <= res_im_in;
    end

    assign ctl_out    = ctl_reg;
    assign den_out    = den_reg;
    assign rem_re_out = rem_re_reg;
    assign rem_im_out = rem_im_reg;
    assign q_re_out   = q_re_reg;
    assign q_im_out   = q_im_reg;
    assign res_re_out = res_re_reg;
    assign res_im_out = res_im_reg;

endmodule

>>> rtl/cau_back.sv
// final stage: signs and saturates quotients, selects and registers the result
module cau_back #(
    parameter int WORD_BITS = cau_pkg::CAU_WORD_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cau_pkg::cau_ctl_t           ctl_in,
    input  logic [WORD_BITS:0]          q_re_in,
    input  logic [WORD_BITS:0]          q_im_in,
    input  logic [WORD_BITS-1:0]        res_re_in,
    input  logic [WORD_BITS-1:0]        res_im_in,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] res_re,
    output logic signed [WORD_BITS-1:0] res_im,
    output logic                        div_by_zero,
    output logic                        overflow,
    output logic                        operands_equal
);
    import cau_pkg::*;

    localparam int W = WORD_BITS;
    localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};

    logic         ovf_re, ovf_im;
    logic [W-1:0] quo_re, quo_im;
    logic [W-1:0] res_re_next, res_im_next;
    logic         ovf_next;
    logic         done_reg, dz_reg, ovf_reg, eq_reg;
    logic [W-1:0] res_re_reg, res_im_reg;

    // quotient range against the signed word, then apply the sign
    always_comb
    begin
        if (ctl_in.neg_re)
        begin
            ovf_re = ctl_in.big_re || q_re_in[W] || (q_re_in[W-1] && (|q_re_in[W-2:0]));
            quo_re = ovf_re ? WORD_MIN : (~q_re_in[W-1:0]) + 1'b1;
        end
        else
        begin
            ovf_re = ctl_in.big_re || q_re_in[W] || q_re_in[W-1];
            quo_re = ovf_re ? WORD_MAX : q_re_in[W-1:0];
        end
        if (ctl_in.neg_im)
        begin
            ovf_im = ctl_in.big_im || q_im_in[W] || (q_im_in[W-1] && (|q_im_in[W-2:0]));
            quo_im = ovf_im ? WORD_MIN : (~q_im_in[W-1:0]) + 1'b1;
        end
        else
        begin
            ovf_im = ctl_in.big_im || q_im_in[W] || q_im_in[W-1];
            quo_im = ovf_im ? WORD_MAX : q_im_in[W-1:0];
        end
        res_re_next = ctl_in.is_div ? quo_re : res_re_in;
        res_im_next = ctl_in.is_div ? quo_im : res_im_in;
        ovf_next    = ctl_in.is_div ? (ovf_re || ovf_im) : ctl_in.ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            dz_reg   <= 1'b0;
            ovf_reg  <= 1'b0;
            eq_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_in.valid;
            dz_reg   <= ctl_in.valid && ctl_in.dz;
            ovf_reg  <= ctl_in.valid && ovf_next;
            eq_reg   <= ctl_in.valid && ctl_in.eq;
        end
    end

    always_ff @(posedge clk)
    begin
        res_re_reg <= res_re_next;
        res_im_reg <= res_im_next;
    end

    assign done           = done_reg;
    assign res_re         = res_re_reg;
    assign res_im         = res_im_reg;
    assign div_by_zero    = dz_reg;
    assign overflow       = ovf_reg;
    assign operands_equal = eq_reg;

endmodule

>>> rtl/complex_arithmetic_unit.sv
// top level of the pipelined complex arithmetic unit
// Takes one item in every cycle (busy is always low) and returns its result,
// marked by done for one cycle, for every operation alike. Every item passes a
// restoring divider with one quotient bit per pipeline stage over WORD_BITS + 1
// bits, behind five front stages for operand capture, products, sums,
// truncation and saturation, and one output stage. Results cannot be held off.
module complex_arithmetic_unit #(
    parameter int WORD_BITS = cau_pkg::CAU_WORD_BITS,
    parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic signed [WORD_BITS-1:0] a_re,
    input  logic signed [WORD_BITS-1:0] a_im,
    input  logic signed [WORD_BITS-1:0] b_re,
    input  logic signed [WORD_BITS-1:0] b_im,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] res_re,
    output logic signed [WORD_BITS-1:0] res_im,
    output logic                        div_by_zero,
    output logic                        overflow,
    output logic                        operands_equal
);
    import cau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int NW = 2 * W + FRAC_BITS;

    // divider pipeline links, index 0 from the front, W+1 into the back
    cau_ctl_t       ctl_s    [0:W+1];
    logic [2*W-1:0] den_s    [0:W+1];
    logic [NW-1:0]  rem_re_s [0:W+1];
    logic [NW-1:0]  rem_im_s [0:W+1];
    logic [W:0]     q_re_s   [0:W+1];
    logic [W:0]     q_im_s   [0:W+1];
    logic [W-1:0]   res_re_s [0:W+1];
    logic [W-1:0]   res_im_s [0:W+1];

    // never stalls
    assign busy = 1'b0;

    cau_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .action     (action),
        .a_re       (a_re),
        .a_im       (a_im),
        .b_re       (b_re),
        .b_im       (b_im),
        .ctl_out    (ctl_s[0]),
        .den_out    (den_s[0]),
        .rem_re_out (rem_re_s[0]),
        .rem_im_out (rem_im_s[0]),
        .res_re_out (res_re_s[0]),
        .res_im_out (res_im_s[0])
    );

    assign q_re_s[0] = '0;
    assign q_im_s[0] = '0;

    // one stage per quotient bit, most significant first
    for (genvar g = 0; g <= W; g++)
    begin : g_div
        cau_div_stage #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS),
            .K         (W - g)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl_in     (ctl_s[g]),
            .den_in     (den_s[g]),
            .rem_re_in  (rem_re_s[g]),
            .rem_im_in  (rem_im_s[g]),
            .q_re_in    (q_re_s[g]),
            .q_im_in    (q_im_s[g]),
            .res_re_in  (res_re_s[g]),
            .res_im_in  (res_im_s[g]),
            .ctl_out    (ctl_s[g+1]),
            .den_out    (den_s[g+1]),
            .rem_re_out (rem_re_s[g+1]),
            .rem_im_out (rem_im_s[g+1]),
            .q_re_out   (q_re_s[g+1]),
            .q_im_out   (q_im_s[g+1]),
            .res_re_out (res_re_s[g+1]),
            .res_im_out (res_im_s[g+1])
        );
    end

    cau_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl_in         (ctl_s[W+1]),
        .q_re_in        (q_re_s[W+1]),
        .q_im_in        (q_im_s[W+1]),
        .res_re_in      (res_re_s[W+1]),
        .res_im_in      (res_im_s[W+1]),
        .done           (done),
        .res_re         (res_re),
        .res_im         (res_im),
        .div_by_zero    (div_by_zero),
        .overflow       (overflow),
        .operands_equal (operands_equal)
    );

endmodule

>>> rtl/cau_checker.sv
// port-level checks for the complex arithmetic unit, bound to the top level
module cau_checker #(
    parameter int WORD_BITS = cau_pkg::CAU_WORD_BITS
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [1:0]                  action,
    input logic signed [WORD_BITS-1:0] a_re,
    input logic signed [WORD_BITS-1:0] a_im,
    input logic signed [WORD_BITS-1:0] b_re,
    input logic signed [WORD_BITS-1:0] b_im,
    input logic                        done,
    input logic signed [WORD_BITS-1:0] res_im,
    input logic                        div_by_zero,
    input logic                        overflow,
    input logic                        operands_equal
);
    import cau_pkg::*;

    localparam int LATENCY = WORD_BITS + 7;

    // every accepted item comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("item result missing at fixed latency");

    // equal operands are flagged on the matching result
    a_equal: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (a_re == b_re) && (a_im == b_im) |-> ##LATENCY operands_equal)
        else $error("equal operands not flagged");

    // a zero divisor on a divide gives the flag and a zero imaginary part
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (action == ACT_DIV) && (b_re == '0) && (b_im == '0)
        |-> ##LATENCY (div_by_zero && (res_im == '0)))
        else $error("division by zero not reported");

    // flags only accompany a result
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> !div_by_zero && !overflow && !operands_equal)
        else $error("flag without result");

endmodule

bind complex_arithmetic_unit cau_checker #(.WORD_BITS(WORD_BITS)) u_cau_checker (.*);
